// ===== hw/rtl/bdla_pkg.sv =====
package bdla_pkg;

   // configuration field widths
   localparam int CFG_DIM_W  = 13;
   localparam int CFG_CELL_W = 9;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // reset values of the configuration registers
   localparam logic [CFG_DIM_W-1:0]  SOURCE_WIDTH_RST  = 13'd640;
   localparam logic [CFG_DIM_W-1:0]  SOURCE_HEIGHT_RST = 13'd480;
   localparam logic [CFG_CELL_W-1:0] CELLS_ACROSS_RST  = 9'd80;
   localparam logic [CFG_CELL_W-1:0] CELLS_DOWN_RST    = 9'd25;

   // row grid limits
   localparam int ROW_CELL_LIMIT = 256;
   localparam int ROW_CNT_W      = 9;
   localparam int ROW_W          = 8;

   // luminance arithmetic, weights scaled by 10000
   localparam int LUMA_W = 22;
   localparam int SUM_W  = 48;
   localparam logic [LUMA_W-1:0] WEIGHT_RED   = 22'd2126;
   localparam logic [LUMA_W-1:0] WEIGHT_GREEN = 22'd7152;
   localparam logic [LUMA_W-1:0] WEIGHT_BLUE  = 22'd722;
   localparam logic [LUMA_W-1:0] LUMA_FULL    = 22'd2550000;

   // gradient index range
   localparam int QUOT_W = 5;
   localparam logic [QUOT_W-1:0] GRADIENT_STEPS = 5'd16;

   // register map
   typedef enum logic [1:0] {
      REG_SOURCE_WIDTH  = 2'd0,
      REG_SOURCE_HEIGHT = 2'd1,
      REG_CELLS_ACROSS  = 2'd2,
      REG_CELLS_DOWN    = 2'd3
   } csr_reg_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } state_type;

   // gradient character for an index 0..16, darkest first
   function automatic logic [6:0] glyph_of(input logic [QUOT_W-1:0] idx);
      logic [6:0] ch;
      case (idx)
         5'd0:    ch = 7'h20;
         5'd1:    ch = 7'h2E;
         5'd2:    ch = 7'h3A;
         5'd3:    ch = 7'h21;
         5'd4:    ch = 7'h2F;
         5'd5:    ch = 7'h72;
         5'd6:    ch = 7'h28;
         5'd7:    ch = 7'h6C;
         5'd8:    ch = 7'h31;
         5'd9:    ch = 7'h5A;
         5'd10:   ch = 7'h34;
         5'd11:   ch = 7'h48;
         5'd12:   ch = 7'h39;
         5'd13:   ch = 7'h57;
         5'd14:   ch = 7'h38;
         5'd15:   ch = 7'h24;
         default: ch = 7'h40;
      endcase
      return ch;
   endfunction

endpackage

// ===== hw/rtl/box_downscale_luma_to_ascii.sv =====
// a cell-completing pixel passes READ, MUL and DIV; its glyph is loaded in EMIT
// each pixel takes a column-sum memory read, then add and write back, with input stalled;
//   a pixel that completes a cell also takes the sample-count multiply and 5 quotient steps
// reset or any register write restarts the frame: a restoring divide pass finds the cell
//   pitch while input is stalled
// column sums restart from zero through per-column valid bits, no clearing pass
module box_downscale_luma_to_ascii import bdla_pkg::*; #(
   parameter int MAX_SOURCE_DIM   = 4096,
   parameter int MAX_CELLS_ACROSS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,
   // glyph output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [6:0]            rsp_glyph,
   output logic [7:0]            rsp_cell_column,
   output logic [7:0]            rsp_cell_row,
   output logic                  rsp_frame_done,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int DIM_W    = $clog2(MAX_SOURCE_DIM + 1);
   localparam int CA_W     = $clog2(MAX_CELLS_ACROSS);
   localparam int CA_CNT_W = $clog2(MAX_CELLS_ACROSS + 1);
   localparam int ICNT_W   = $clog2(DIM_W);
   localparam int SAMP_W   = 2 * DIM_W;
   localparam int DEN_W    = SAMP_W + LUMA_W;
   localparam int NUM_W    = ((SUM_W > DEN_W) ? SUM_W : DEN_W) + 5;

   // configuration registers
   logic [CFG_DIM_W-1:0]  src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [CFG_CELL_W-1:0] cells_ac_ff, cells_ac_in, cells_dn_ff, cells_dn_in;
   logic                  cfg_wr, restart;
   csr_reg_type           cfg_idx;

   // effective frame geometry
   logic [31:0]           w_clamp, h_clamp, ca_clamp, cd_clamp;
   logic [DIM_W-1:0]      eff_w_ff, eff_w_in, eff_h_ff, eff_h_in;
   logic [CA_CNT_W-1:0]   eff_ca_ff, eff_ca_in;
   logic [ROW_CNT_W-1:0]  eff_cd_ff, eff_cd_in;

   // pitch divider
   logic [ICNT_W-1:0]     init_cnt_ff;
   logic                  init_last;
   logic [DIM_W-1:0]      divc_ff, divc_step, divr_ff, divr_step;
   logic [CA_CNT_W-1:0]   remc_ff, remc_step;
   logic [ROW_CNT_W-1:0]  remr_ff, remr_step;
   logic [CA_CNT_W:0]     tc, tc_sub;
   logic [ROW_CNT_W:0]    tr, tr_sub;
   logic                  tc_ge, tr_ge;
   logic [DIM_W-1:0]      qc_ff, qr_ff;
   logic [CA_CNT_W-1:0]   rc_ff;
   logic [ROW_CNT_W-1:0]  rr_ff;

   // raster position
   logic [DIM_W-1:0]      px_ff, px_in, py_ff, py_in, px1, py1;
   logic [CA_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [DIM_W-1:0]      col_start_ff, col_start_in, col_edge_ff, col_edge_in;
   logic [CA_CNT_W-1:0]   col_rem_ff, col_rem_in;
   logic [DIM_W-1:0]      band_ff, band_in, row_edge_ff, row_edge_in;
   logic [ROW_CNT_W-1:0]  row_rem_ff, row_rem_in;
   logic [CA_CNT_W:0]     col_rsum;
   logic [ROW_CNT_W:0]    row_rsum;
   logic                  col_hit, col_more, row_hit, col_carry, row_carry;

   // item in flight
   logic                  accept;
   logic [LUMA_W-1:0]     luma;
   logic [LUMA_W-1:0]     w_ff;
   logic [CA_W-1:0]       colr_ff;
   logic [ROW_W-1:0]      rowr_ff;
   logic                  emit_ff, done_ff;
   logic [DIM_W-1:0]      cw_ff, rh_ff;
   logic [SAMP_W-1:0]     samples_ff;
   logic [DEN_W-1:0]      den_prod;
   logic [NUM_W-1:0]      num_ff, den_sh_ff;
   logic [QUOT_W-1:0]     quot_ff, quot_sat;
   logic [2:0]            step_ff;
   logic                  quot_ge;

   // column sum memory
   logic [MAX_CELLS_ACROSS-1:0] valid_ff;
   logic                  mem_we, mem_re;
   logic [SUM_W-1:0]      mem_rd, sum_new, mem_wd;

   // sequencer and output
   state_type             state_ff, state_in;
   logic                  out_load;
   logic                  rsp_valid_ff;
   logic [6:0]            glyph_ff;
   logic [7:0]            ocol_ff, orow_ff;
   logic                  odone_ff;

   // register writes and reads
   assign pready  = 1'b1;
   assign cfg_wr  = psel & penable & pwrite;
   assign cfg_idx = csr_reg_type'(paddr[3:2]);
   assign restart = reset | cfg_wr;

   always_comb begin
      src_w_in    = src_w_ff;
      src_h_in    = src_h_ff;
      cells_ac_in = cells_ac_ff;
      cells_dn_in = cells_dn_ff;
      if (reset) begin
         src_w_in    = SOURCE_WIDTH_RST;
         src_h_in    = SOURCE_HEIGHT_RST;
         cells_ac_in = CELLS_ACROSS_RST;
         cells_dn_in = CELLS_DOWN_RST;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_SOURCE_WIDTH:  src_w_in    = pwdata[CFG_DIM_W-1:0];
            REG_SOURCE_HEIGHT: src_h_in    = pwdata[CFG_DIM_W-1:0];
            REG_CELLS_ACROSS:  cells_ac_in = pwdata[CFG_CELL_W-1:0];
            REG_CELLS_DOWN:    cells_dn_in = pwdata[CFG_CELL_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      src_w_ff    <= src_w_in;
      src_h_ff    <= src_h_in;
      cells_ac_ff <= cells_ac_in;
      cells_dn_ff <= cells_dn_in;
   end

   always_comb begin
      unique case (cfg_idx)
         REG_SOURCE_WIDTH:  prdata = CSR_DATA_W'(src_w_ff);
         REG_SOURCE_HEIGHT: prdata = CSR_DATA_W'(src_h_ff);
         REG_CELLS_ACROSS:  prdata = CSR_DATA_W'(cells_ac_ff);
         REG_CELLS_DOWN:    prdata = CSR_DATA_W'(cells_dn_ff);
      endcase
   end

   // clamp sizes and cell counts
   always_comb begin
      w_clamp = (src_w_in == '0) ? 32'd1 : 32'(src_w_in);
      if (w_clamp > 32'(MAX_SOURCE_DIM)) w_clamp = 32'(MAX_SOURCE_DIM);
      h_clamp = (src_h_in == '0) ? 32'd1 : 32'(src_h_in);
      if (h_clamp > 32'(MAX_SOURCE_DIM)) h_clamp = 32'(MAX_SOURCE_DIM);
      ca_clamp = (cells_ac_in == '0) ? 32'd1 : 32'(cells_ac_in);
      if (ca_clamp > 32'(MAX_CELLS_ACROSS)) ca_clamp = 32'(MAX_CELLS_ACROSS);
      if (ca_clamp > w_clamp) ca_clamp = w_clamp;
      cd_clamp = (cells_dn_in == '0) ? 32'd1 : 32'(cells_dn_in);
      if (cd_clamp > 32'(ROW_CELL_LIMIT)) cd_clamp = 32'(ROW_CELL_LIMIT);
      if (cd_clamp > h_clamp) cd_clamp = h_clamp;
      eff_w_in  = w_clamp[DIM_W-1:0];
      eff_h_in  = h_clamp[DIM_W-1:0];
      eff_ca_in = ca_clamp[CA_CNT_W-1:0];
      eff_cd_in = cd_clamp[ROW_CNT_W-1:0];
   end

   // restoring divide steps: source size over cell count
   assign tc        = {remc_ff, divc_ff[DIM_W-1]};
   assign tc_ge     = tc >= {1'b0, eff_ca_ff};
   assign tc_sub    = tc - {1'b0, eff_ca_ff};
   assign remc_step = tc_ge ? tc_sub[CA_CNT_W-1:0] : tc[CA_CNT_W-1:0];
   assign divc_step = {divc_ff[DIM_W-2:0], tc_ge};
   assign tr        = {remr_ff, divr_ff[DIM_W-1]};
   assign tr_ge     = tr >= {1'b0, eff_cd_ff};
   assign tr_sub    = tr - {1'b0, eff_cd_ff};
   assign remr_step = tr_ge ? tr_sub[ROW_CNT_W-1:0] : tr[ROW_CNT_W-1:0];
   assign divr_step = {divr_ff[DIM_W-2:0], tr_ge};
   assign init_last = (state_ff == ST_INIT) && (init_cnt_ff == ICNT_W'(DIM_W - 1));

   always_ff @(posedge clock) begin
      if (restart) begin
         eff_w_ff  <= eff_w_in;
         eff_h_ff  <= eff_h_in;
         eff_ca_ff <= eff_ca_in;
         eff_cd_ff <= eff_cd_in;
         divc_ff   <= eff_w_in;
         divr_ff   <= eff_h_in;
         remc_ff   <= '0;
         remr_ff   <= '0;
      end else if (state_ff == ST_INIT) begin
         divc_ff <= divc_step;
         divr_ff <= divr_step;
         remc_ff <= remc_step;
         remr_ff <= remr_step;
      end
      if (init_last) begin
         qc_ff <= divc_step;
         rc_ff <= remc_step;
         qr_ff <= divr_step;
         rr_ff <= remr_step;
      end
   end

   always_ff @(posedge clock) begin
      if (restart) begin
         init_cnt_ff <= '0;
      end else if (state_ff == ST_INIT) begin
         init_cnt_ff <= init_cnt_ff + 1'b1;
      end
   end

   // raster walk with incremental cell edges
   assign accept    = req_valid & ~req_stall;
   assign px1       = px_ff + 1'b1;
   assign py1       = py_ff + 1'b1;
   assign col_hit   = px1 >= col_edge_ff;
   assign row_hit   = py1 >= row_edge_ff;
   assign col_more  = (32'(col_ff) + 32'd1) < 32'(eff_ca_ff);
   assign col_rsum  = {1'b0, col_rem_ff} + {1'b0, rc_ff};
   assign col_carry = col_rsum >= {1'b0, eff_ca_ff};
   assign row_rsum  = {1'b0, row_rem_ff} + {1'b0, rr_ff};
   assign row_carry = row_rsum >= {1'b0, eff_cd_ff};

   always_comb begin
      px_in        = px_ff;
      py_in        = py_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      col_start_in = col_start_ff;
      col_edge_in  = col_edge_ff;
      col_rem_in   = col_rem_ff;
      band_in      = band_ff;
      row_edge_in  = row_edge_ff;
      row_rem_in   = row_rem_ff;
      if (init_last) begin
         px_in        = '0;
         py_in        = '0;
         col_in       = '0;
         row_in       = '0;
         col_start_in = '0;
         col_edge_in  = divc_step;
         col_rem_in   = remc_step;
         band_in      = '0;
         row_edge_in  = divr_step;
         row_rem_in   = remr_step;
      end else if (accept) begin
         if (col_hit && col_more) begin
            col_in       = col_ff + 1'b1;
            col_start_in = col_edge_ff;
            col_edge_in  = col_edge_ff + qc_ff + DIM_W'(col_carry);
            col_rem_in   = col_carry ? CA_CNT_W'(col_rsum - {1'b0, eff_ca_ff})
                                     : col_rsum[CA_CNT_W-1:0];
         end
         px_in = px1;
         if (px1 >= eff_w_ff) begin
            px_in        = '0;
            col_in       = '0;
            col_start_in = '0;
            col_edge_in  = qc_ff;
            col_rem_in   = rc_ff;
            py_in        = py1;
            if (py1 >= eff_h_ff) begin
               py_in       = '0;
               row_in      = '0;
               band_in     = '0;
               row_edge_in = qr_ff;
               row_rem_in  = rr_ff;
            end else if (row_hit) begin
               if ((32'(row_ff) + 32'd1) < 32'(eff_cd_ff)) row_in = row_ff + 1'b1;
               band_in     = py1;
               row_edge_in = row_edge_ff + qr_ff + DIM_W'(row_carry);
               row_rem_in  = row_carry ? ROW_CNT_W'(row_rsum - {1'b0, eff_cd_ff})
                                       : row_rsum[ROW_CNT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      col_start_ff <= col_start_in;
      col_edge_ff  <= col_edge_in;
      col_rem_ff   <= col_rem_in;
      band_ff      <= band_in;
      row_edge_ff  <= row_edge_in;
      row_rem_ff   <= row_rem_in;
   end

   // weighted luminance of the beat
   assign luma = LUMA_W'(req_red) * WEIGHT_RED + LUMA_W'(req_green) * WEIGHT_GREEN
               + LUMA_W'(req_blue) * WEIGHT_BLUE;

   // capture the item and its cell
   always_ff @(posedge clock) begin
      if (accept) begin
         w_ff    <= luma;
         colr_ff <= col_ff;
         rowr_ff <= row_ff;
         emit_ff <= col_hit && row_hit;
         done_ff <= !col_more && ((32'(row_ff) + 32'd1) >= 32'(eff_cd_ff));
         cw_ff   <= col_edge_ff - col_start_ff;
         rh_ff   <= row_edge_ff - band_ff;
      end
   end

   // column sum memory, read on accept, written back in the next cycle
   bdla_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_CELLS_ACROSS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (colr_ff),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (col_ff),
      .rd_data (mem_rd)
   );

   assign sum_new = (valid_ff[colr_ff] ? mem_rd : '0) + SUM_W'(w_ff);
   assign mem_wd  = emit_ff ? '0 : sum_new;

   always_ff @(posedge clock) begin
      if (restart) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[colr_ff] <= 1'b1;
      end
   end

   // average: compare 16*sum with shifted sample denominator
   assign den_prod = DEN_W'(samples_ff) * DEN_W'(LUMA_FULL);
   assign quot_ge  = num_ff >= den_sh_ff;

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_READ: begin
            num_ff     <= NUM_W'(sum_new) << 4;
            samples_ff <= SAMP_W'(cw_ff) * SAMP_W'(rh_ff);
         end
         ST_MUL: begin
            den_sh_ff <= NUM_W'(den_prod) << 4;
            quot_ff   <= '0;
            step_ff   <= 3'd4;
         end
         ST_DIV: begin
            if (quot_ge) num_ff <= num_ff - den_sh_ff;
            den_sh_ff <= den_sh_ff >> 1;
            quot_ff   <= {quot_ff[QUOT_W-2:0], quot_ge};
            step_ff   <= step_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: if (init_last) state_in = ST_IDLE;
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = emit_ff ? ST_MUL : ST_IDLE;
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  if (step_ff == '0) state_in = ST_EMIT;
         ST_EMIT: if (out_load) state_in = ST_IDLE;
         default: state_in = ST_INIT;
      endcase
      if (restart) state_in = ST_INIT;
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            mem_re    = req_valid;
         end
         ST_READ: mem_we = 1'b1;
         ST_EMIT: out_load = ~rsp_valid_ff | ~rsp_stall;
         default: begin
         end
      endcase
   end

   // output register
   assign quot_sat = (quot_ff > GRADIENT_STEPS) ? GRADIENT_STEPS : quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         glyph_ff <= glyph_of(quot_sat);
         ocol_ff  <= 8'(colr_ff);
         orow_ff  <= rowr_ff;
         odone_ff <= done_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_glyph       = glyph_ff;
   assign rsp_cell_column = ocol_ff;
   assign rsp_cell_row    = orow_ff;
   assign rsp_frame_done  = odone_ff;

   // column index stays inside the grid
   a_col_in_grid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> 32'(col_ff) < 32'(eff_ca_ff))
      else $error("cell column outside grid");

   // edge remainder stays below the cell count
   a_col_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> col_rem_ff < eff_ca_ff)
      else $error("column edge remainder out of range");

   // a finished cell always has samples
   a_samples: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> samples_ff != '0)
      else $error("empty cell reached the divider");

   // the average never exceeds full scale
   a_quot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> quot_ff <= GRADIENT_STEPS)
      else $error("gradient index above full scale");

   // a loaded glyph is presented next cycle
   a_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("loaded glyph not presented");

endmodule

// ===== hw/rtl/bdla_ram.sv =====
module bdla_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== test/tb_box_downscale_luma_to_ascii.sv =====
module tb_box_downscale_luma_to_ascii;
   import bdla_pkg::*;

   localparam int SUM_MASK_BITS = 48;
   localparam int QUIET_LIMIT   = 3000;
   localparam int DRAIN_CYCLES  = 14;
   localparam string GRADIENT   = " .:!/r(l1Z4H9W8$@";

   typedef struct packed {
      logic [6:0] glyph;
      logic [7:0] cell_column;
      logic [7:0] cell_row;
      logic       frame_done;
   } glyph_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_red = '0;
   logic [7:0]            req_green = '0;
   logic [7:0]            req_blue = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [6:0]            rsp_glyph;
   logic [7:0]            rsp_cell_column;
   logic [7:0]            rsp_cell_row;
   logic                  rsp_frame_done;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   box_downscale_luma_to_ascii DUT (.*);

   always #6 clock = ~clock;

   // register copies and effective grid
   logic [CFG_DIM_W-1:0]  reg_width, reg_height;
   logic [CFG_CELL_W-1:0] reg_across, reg_down;
   int unsigned eff_w, eff_h, eff_ca, eff_cd;

   // running predictor state
   logic [SUM_MASK_BITS-1:0] col_sums [256];
   int unsigned pix_x, pix_y, cur_col, cur_row, col_edge, row_edge, band_top;

   glyph_beat_type expected_beats [$];
   int failures = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   bit receiver_hold = 1'b0;
   int quiet_cycles = 0;

   function automatic int unsigned cell_bound(int unsigned k, int unsigned src,
                                              int unsigned dst);
      longint unsigned prod;
      if (k >= dst) return src;
      prod = longint'(k) * longint'(src);
      return int'(prod / dst);
   endfunction

   function automatic int unsigned clamp_to(int unsigned v, int unsigned lo,
                                            int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // restart the frame under the current register values
   function automatic void restart_grid();
      eff_w  = clamp_to(reg_width, 1, 4096);
      eff_h  = clamp_to(reg_height, 1, 4096);
      eff_ca = clamp_to(reg_across, 1, 256);
      if (eff_ca > eff_w) eff_ca = eff_w;
      eff_cd = clamp_to(reg_down, 1, ROW_CELL_LIMIT);
      if (eff_cd > eff_h) eff_cd = eff_h;
      foreach (col_sums[i]) col_sums[i] = '0;
      pix_x = 0; pix_y = 0; cur_col = 0; cur_row = 0; band_top = 0;
      col_edge = cell_bound(1, eff_w, eff_ca);
      row_edge = cell_bound(1, eff_h, eff_cd);
   endfunction

   // accumulate one pixel and queue the glyph of any cell it completes
   function automatic void luma_accumulate(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      longint unsigned weight, samples, idx;
      int unsigned col, col_start;
      glyph_beat_type exp_beat;
      byte ch;
      weight = 2126 * longint'(r) + 7152 * longint'(g) + 722 * longint'(b);
      col = cur_col;
      col_sums[col] = col_sums[col] + weight;
      if (pix_x + 1 >= col_edge) begin
         if (pix_y + 1 >= row_edge) begin
            col_start = cell_bound(col, eff_w, eff_ca);
            samples = longint'(col_edge - col_start) * longint'(row_edge - band_top);
            idx = 0;
            if (samples != 0) idx = (16 * longint'(col_sums[col])) / (samples * 2550000);
            if (idx > 16) idx = 16;
            ch = GRADIENT[idx];
            exp_beat.glyph       = ch[6:0];
            exp_beat.cell_column = col[7:0];
            exp_beat.cell_row    = cur_row[7:0];
            exp_beat.frame_done  = (col + 1 >= eff_ca) && (cur_row + 1 >= eff_cd);
            expected_beats.push_back(exp_beat);
            col_sums[col] = '0;
         end
         if (col + 1 < eff_ca) begin
            cur_col  = col + 1;
            col_edge = cell_bound(col + 2, eff_w, eff_ca);
         end
      end
      pix_x++;
      if (pix_x >= eff_w) begin
         pix_x = 0;
         cur_col = 0;
         col_edge = cell_bound(1, eff_w, eff_ca);
         pix_y++;
         if (pix_y >= eff_h) begin
            pix_y = 0; cur_row = 0; band_top = 0;
            row_edge = cell_bound(1, eff_h, eff_cd);
         end else if (pix_y >= row_edge) begin
            if (cur_row + 1 < eff_cd) cur_row++;
            band_top = pix_y;
            row_edge = cell_bound(cur_row + 1, eff_h, eff_cd);
         end
      end
   endfunction

   // receiver stall pattern, with an optional long hold-off
   always @(posedge clock) begin
      rsp_stall <= receiver_hold || ($urandom_range(99) < receiver_stall_pct);
   end

   // compare each accepted glyph beat with the oldest expectation
   always @(posedge clock) begin
      glyph_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected glyph beat col %0d row %0d", rsp_cell_column, rsp_cell_row);
            failures++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_glyph !== want.glyph) begin
               $error("glyph exp %0d got %0d", want.glyph, rsp_glyph);
               failures++;
            end
            if (rsp_cell_column !== want.cell_column) begin
               $error("cell_column exp %0d got %0d", want.cell_column, rsp_cell_column);
               failures++;
            end
            if (rsp_cell_row !== want.cell_row) begin
               $error("cell_row exp %0d got %0d", want.cell_row, rsp_cell_row);
               failures++;
            end
            if (rsp_frame_done !== want.frame_done) begin
               $error("frame_done exp %0d got %0d", want.frame_done, rsp_frame_done);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      luma_accumulate(r, g, b);
   endtask

   task automatic send_random_pixel();
      logic [7:0] r, g, b;
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      case ($urandom_range(7))
         0: begin r = '0; g = '0; b = '0; end
         1: begin r = '1; g = '1; b = '1; end
         default: ;
      endcase
      send_pixel(r, g, b);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write while the block is idle
   task automatic csr_write(csr_reg_type which, int unsigned value);
      drain();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {which, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (which)
         REG_SOURCE_WIDTH:  reg_width  = value[CFG_DIM_W-1:0];
         REG_SOURCE_HEIGHT: reg_height = value[CFG_DIM_W-1:0];
         REG_CELLS_ACROSS:  reg_across = value[CFG_CELL_W-1:0];
         REG_CELLS_DOWN:    reg_down   = value[CFG_CELL_W-1:0];
      endcase
      restart_grid();
   endtask

   task automatic set_grid(int unsigned w, int unsigned h, int unsigned ca, int unsigned cd);
      csr_write(REG_SOURCE_WIDTH, w);
      csr_write(REG_SOURCE_HEIGHT, h);
      csr_write(REG_CELLS_ACROSS, ca);
      csr_write(REG_CELLS_DOWN, cd);
   endtask

   // zero sizes, saturation and the extremes of the channels
   task automatic test_directed();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      set_grid(0, 0, 0, 0);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hAA, 8'h55, 8'hAA);
      send_pixel(8'h55, 8'hAA, 8'h55);
      // more cells than columns saturates to the width
      set_grid(3, 2, 9, 1);
      repeat (6) send_random_pixel();
      set_grid(5, 5, 2, 3);
      repeat (12) send_random_pixel();
   endtask

   // widest and tallest frames, cell counts beyond their limits
   task automatic test_extreme_frames();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      set_grid(8191, 1, 511, 1);
      repeat (48) send_random_pixel();
      set_grid(1, 4096, 1, 256);
      repeat (48) send_random_pixel();
   endtask

   task automatic test_random_frames(int send_pct, int recv_pct, int count);
      int sent, frames, pixels;
      sender_idle_pct = send_pct;
      receiver_stall_pct = recv_pct;
      sent = 0;
      while (sent < count) begin
         set_grid($urandom_range(20, 1), $urandom_range(12, 1),
                  $urandom_range(24, 0), $urandom_range(15, 0));
         frames = $urandom_range(2, 1);
         pixels = frames * eff_w * eff_h;
         // now and then cut a frame short before the next setting
         if ($urandom_range(4) == 0) pixels = $urandom_range(eff_w * eff_h);
         if (pixels > count - sent) pixels = count - sent;
         repeat (pixels) send_random_pixel();
         sent += pixels;
      end
   endtask

   // receiver holds off while pixels keep coming, so the input backs up
   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      set_grid(16, 4, 8, 4);
      fork
         begin
            receiver_hold = 1'b1;
            repeat (300) @(posedge clock);
            receiver_hold = 1'b0;
         end
      join_none
      repeat (64) send_random_pixel();
   endtask

   initial begin
      reg_width  = SOURCE_WIDTH_RST;
      reg_height = SOURCE_HEIGHT_RST;
      reg_across = CELLS_ACROSS_RST;
      reg_down   = CELLS_DOWN_RST;
      restart_grid();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_frames(35, 53, 256);
      test_random_frames(53, 35, 256);
      test_random_frames(0, 0, 256);
      test_backpressure();
      test_extreme_frames();
      drain();
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== box_downscale_luma_to_ascii.f =====
hw/rtl/bdla_pkg.sv
hw/rtl/bdla_ram.sv
hw/rtl/box_downscale_luma_to_ascii.sv
test/tb_box_downscale_luma_to_ascii.sv
